@@ rtl/pointer_cursor_click_detector_defines.svh @@
// assertion macros for the pointer cursor click detector checker
// expects clk and rst in scope where a macro is used
`ifndef POINTER_CURSOR_CLICK_DETECTOR_DEFINES_SVH
`define POINTER_CURSOR_CLICK_DETECTOR_DEFINES_SVH

// same-cycle implication
`define PCCD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCCD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pccd_pkg.sv @@
// shared types and constants for the pointer cursor click detector
// no dependencies
package pccd_pkg;

  localparam int PCCD_COORD_BITS = 12;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 2;
  localparam int TIME_W          = 32;
  localparam int DELTA_W         = 16;
  localparam int FRAC_W          = 17;
  localparam int FRAC_SHIFT      = 16;
  localparam int BUTTON_W        = 8;

  // reset values, wide enough for the largest coordinate width
  localparam logic [15:0] MAX_X_RESET  = 16'd1023;
  localparam logic [15:0] MAX_Y_RESET  = 16'd767;
  localparam logic [15:0] CUR_X_RESET  = 16'd511;
  localparam logic [15:0] CUR_Y_RESET  = 16'd383;
  localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd400;

  localparam logic [BUTTON_W-1:0] BUTTON_PRIMARY = 8'd0;

  typedef enum logic [1:0] {
    CMD_REL_MOVE = 2'd0,
    CMD_ABS_MOVE = 2'd1,
    CMD_BTN_DOWN = 2'd2,
    CMD_BTN_UP   = 2'd3
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_X         = 2'd0,
    REG_MAX_Y         = 2'd1,
    REG_DCLICK_WINDOW = 2'd2
  } cfg_reg_t;

endpackage

@@ rtl/pccd_axis.sv @@
// one cursor axis: relative move with saturation, or absolute move by
// scaling a Q1.16 fraction with the axis limit; depends on pccd_pkg
module pccd_axis
  import pccd_pkg::*;
#(
  parameter int COORD_BITS = PCCD_COORD_BITS
) (
  input  cmd_t                       command,
  input  logic [COORD_BITS-1:0]      pos,
  input  logic signed [DELTA_W-1:0]  delta,
  input  logic [FRAC_W-1:0]          frac,
  input  logic [COORD_BITS-1:0]      limit,
  output logic [COORD_BITS-1:0]      next_pos
);

  localparam int SUM_W  = DELTA_W + 2;
  localparam int PROD_W = FRAC_W + COORD_BITS;

  logic signed [SUM_W-1:0]  pos_ext;
  logic signed [SUM_W-1:0]  delta_ext;
  logic signed [SUM_W-1:0]  limit_ext;
  logic signed [SUM_W-1:0]  sum;
  logic [COORD_BITS-1:0]    rel_pos;
  logic [PROD_W-1:0]        prod;
  logic [COORD_BITS:0]      scaled;
  logic [COORD_BITS-1:0]    abs_pos;

  // relative move, saturated to 0..limit
  assign pos_ext   = signed'({{(SUM_W-COORD_BITS){1'b0}}, pos});
  assign limit_ext = signed'({{(SUM_W-COORD_BITS){1'b0}}, limit});
  assign delta_ext = {{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta};
  assign sum       = pos_ext + delta_ext;

  always_comb begin
    if (sum[SUM_W-1]) begin
      rel_pos = '0;
    end else if (sum > limit_ext) begin
      rel_pos = limit;
    end else begin
      rel_pos = sum[COORD_BITS-1:0];
    end
  end

  // absolute move, fraction bits dropped, fractions above one saturate
  assign prod   = PROD_W'(frac) * PROD_W'(limit);
  assign scaled = prod[PROD_W-1:FRAC_SHIFT];

  always_comb begin
    if (scaled > {1'b0, limit}) begin
      abs_pos = limit;
    end else begin
      abs_pos = scaled[COORD_BITS-1:0];
    end
  end

  always_comb begin
    case (command)
      CMD_REL_MOVE: next_pos = rel_pos;
      CMD_ABS_MOVE: next_pos = abs_pos;
      default:      next_pos = pos;
    endcase
  end

endmodule

@@ rtl/pointer_cursor_click_detector.sv @@
// channel  dir  handshake              word
// in       in   in_valid / in_ready    command, deltas, fractions, button, time_now
// out      out  out_valid / out_ready  cursor_x, cursor_y, moved, click, double_click
// cfg      in   cfg_wr_en              cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; an accepted word passes
// through the input register, then the result register, and cursor and click
// state are updated at the same edge as the result register.
// in_ready falls only while both registers hold words and out_ready is low.
// rst is synchronous and returns cursor, click history and registers to their
// defaults.
// top level; depends on pccd_pkg and pccd_axis
module pointer_cursor_click_detector
  import pccd_pkg::*;
#(
  parameter int COORD_BITS = PCCD_COORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic signed [DELTA_W-1:0]   delta_x,
  input  logic signed [DELTA_W-1:0]   delta_y,
  input  logic [FRAC_W-1:0]           abs_x_frac,
  input  logic [FRAC_W-1:0]           abs_y_frac,
  input  logic [BUTTON_W-1:0]         button,
  input  logic [TIME_W-1:0]           time_now,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [COORD_BITS-1:0]       cursor_x,
  output logic [COORD_BITS-1:0]       cursor_y,
  output logic                        moved,
  output logic                        click,
  output logic                        double_click,
  input  logic                        cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  // input register
  logic                        s1_valid;
  cmd_t                        s1_cmd;
  logic signed [DELTA_W-1:0]   s1_dx;
  logic signed [DELTA_W-1:0]   s1_dy;
  logic [FRAC_W-1:0]           s1_fx;
  logic [FRAC_W-1:0]           s1_fy;
  logic [BUTTON_W-1:0]         s1_button;
  logic [TIME_W-1:0]           s1_time;

  // configuration
  logic [COORD_BITS-1:0]       max_x;
  logic [COORD_BITS-1:0]       max_y;
  logic [TIME_W-1:0]           dclick_window;

  // cursor and click state
  logic [COORD_BITS-1:0]       cur_x;
  logic [COORD_BITS-1:0]       cur_y;
  logic [COORD_BITS-1:0]       press_x;
  logic [COORD_BITS-1:0]       press_y;
  logic                        prev_click_valid;
  logic [COORD_BITS-1:0]       prev_click_x;
  logic [COORD_BITS-1:0]       prev_click_y;
  logic [TIME_W-1:0]           prev_click_time;

  logic [COORD_BITS-1:0]       cur_x_next;
  logic [COORD_BITS-1:0]       cur_y_next;
  logic                        s1_adv;
  logic                        is_primary;
  logic                        is_move;
  logic                        press_hit;
  logic                        click_hit;
  logic                        dclick_hit;
  logic [TIME_W-1:0]           click_age;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  pccd_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .command  (s1_cmd),
    .pos      (cur_x),
    .delta    (s1_dx),
    .frac     (s1_fx),
    .limit    (max_x),
    .next_pos (cur_x_next)
  );

  pccd_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .command  (s1_cmd),
    .pos      (cur_y),
    .delta    (s1_dy),
    .frac     (s1_fy),
    .limit    (max_y),
    .next_pos (cur_y_next)
  );

  assign is_primary = (s1_button == BUTTON_PRIMARY);
  assign is_move    = (s1_cmd == CMD_REL_MOVE) || (s1_cmd == CMD_ABS_MOVE);
  assign press_hit  = (s1_cmd == CMD_BTN_DOWN) && is_primary;
  assign click_hit  = (s1_cmd == CMD_BTN_UP) && is_primary &&
                      (press_x == cur_x) && (press_y == cur_y);
  // wrapping age of the previous click
  assign click_age  = s1_time - prev_click_time;
  assign dclick_hit = click_hit && prev_click_valid &&
                      (prev_click_x == cur_x) && (prev_click_y == cur_y) &&
                      (click_age <= dclick_window);

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      max_x            <= MAX_X_RESET[COORD_BITS-1:0];
      max_y            <= MAX_Y_RESET[COORD_BITS-1:0];
      dclick_window    <= WINDOW_RESET;
      cur_x            <= CUR_X_RESET[COORD_BITS-1:0];
      cur_y            <= CUR_Y_RESET[COORD_BITS-1:0];
      press_x          <= '0;
      press_y          <= '0;
      prev_click_valid <= 1'b0;
      prev_click_x     <= '0;
      prev_click_y     <= '0;
      prev_click_time  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAX_X:         max_x <= cfg_data[COORD_BITS-1:0];
          REG_MAX_Y:         max_y <= cfg_data[COORD_BITS-1:0];
          REG_DCLICK_WINDOW: dclick_window <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      if (s1_adv) begin
        cur_x <= cur_x_next;
        cur_y <= cur_y_next;
        if (press_hit) begin
          press_x <= cur_x;
          press_y <= cur_y;
        end
        if (dclick_hit) begin
          prev_click_valid <= 1'b0;
        end else if (click_hit) begin
          prev_click_valid <= 1'b1;
          prev_click_x     <= cur_x;
          prev_click_y     <= cur_y;
          prev_click_time  <= s1_time;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd    <= cmd_t'(command);
      s1_dx     <= delta_x;
      s1_dy     <= delta_y;
      s1_fx     <= abs_x_frac;
      s1_fy     <= abs_y_frac;
      s1_button <= button;
      s1_time   <= time_now;
    end
    if (s1_adv) begin
      cursor_x     <= cur_x_next;
      cursor_y     <= cur_y_next;
      moved        <= is_move;
      click        <= click_hit;
      double_click <= dclick_hit;
    end
  end

endmodule

@@ rtl/pccd_checker.sv @@
// port-level checks for the pointer cursor click detector, with its bind
// depends on pointer_cursor_click_detector_defines.svh
`include "pointer_cursor_click_detector_defines.svh"

module pccd_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] cursor_x,
  input logic [COORD_BITS-1:0] cursor_y,
  input logic                  moved,
  input logic                  click,
  input logic                  double_click
);

  `PCCD_ASSERT_IMPL(a_dclick_is_click, out_valid && double_click, click, "double click without click")
  `PCCD_ASSERT_IMPL(a_move_not_click, out_valid && moved, !click && !double_click, "move word flags a click")
  `PCCD_ASSERT_IMPL(a_quiet_after_reset, $past(rst), !out_valid, "result word straight after reset")
  `PCCD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(cursor_x) && $stable(cursor_y) && $stable(moved) && $stable(click) && $stable(double_click), "stalled result word changed")

endmodule

bind pointer_cursor_click_detector pccd_checker #(.COORD_BITS(COORD_BITS)) u_pccd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cursor_x     (cursor_x),
  .cursor_y     (cursor_y),
  .moved        (moved),
  .click        (click),
  .double_click (double_click)
);
